### rtl/lrr_pkg.sv
// Package: shared types, constants and defaults for the ranged Lehmer generator.
`default_nettype none

package lrr_pkg;

   // Field widths
   localparam int SEED_W = 31;
   localparam int WORD_W = 32;
   localparam int MULT_W = 15;
   localparam int PROD_W = SEED_W + MULT_W;
   localparam int SCALE_W = SEED_W + WORD_W;

   // Minimal standard recurrence constants
   localparam logic [MULT_W-1:0] LcgMult = 15'd16807;
   localparam logic [SEED_W-1:0] LcgMod = 31'h7FFF_FFFF;
   localparam logic [SEED_W-1:0] SeedReset = 31'd12345678;

   // Default depth of the job queue between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // Request payload
   typedef struct packed {
      logic signed [WORD_W-1:0] range_low;
      logic signed [WORD_W-1:0] range_high;
   } req_type;

   // Result payload
   typedef struct packed {
      logic signed [WORD_W-1:0] ranged_value;
      logic [SEED_W-1:0] unit_fraction;
   } rsp_type;

   // Ordered job handed from front to back: lower bound and span minus one
   typedef struct packed {
      logic [WORD_W-1:0] low;
      logic [WORD_W-1:0] diff;
   } job_type;

endpackage

`default_nettype wire

### rtl/lrr_front.sv
// Front end: order the bounds of a request and form the span for the back end.
`default_nettype none

module lrr_front
   import lrr_pkg::*;
(
   input  var req_type req_data,
   output job_type job_data
);

   logic swap;

   // Swap reversed bounds, then take the span minus one as an unsigned word
   always_comb begin
      swap = (req_data.range_high < req_data.range_low);
      if (swap) begin
         job_data.low = req_data.range_high;
         job_data.diff = WORD_W'(req_data.range_low - req_data.range_high);
      end else begin
         job_data.low = req_data.range_low;
         job_data.diff = WORD_W'(req_data.range_high - req_data.range_low);
      end
   end

endmodule

`default_nettype wire

### rtl/lrr_queue.sv
// Job queue: short FIFO between the front end and the back end, registered read.
`default_nettype none

module lrr_queue
   import lrr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  var logic clock,
   input  var logic reset,
   input  var logic push,
   input  var job_type push_data,
   output var logic full,
   output var logic not_empty,
   input  var logic pop,
   output job_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FullCount = CNT_W'(DEPTH);

   job_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   job_type pop_data_ff;

   assign full = (count_ff == FullCount);
   assign not_empty = (count_ff != '0);
   assign pop_data = pop_data_ff;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store on push, hand out the head entry on pop
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (pop) begin
         pop_data_ff <= mem[rd_ptr_ff];
      end
   end

endmodule

`default_nettype wire

### rtl/lrr_back.sv
// Back end: advance the seed, scale it into the range and hold the result.
`default_nettype none

module lrr_back
   import lrr_pkg::*;
(
   input  var logic clock,
   input  var logic reset,
   input  var logic job_ready,
   output var logic job_pop,
   input  var job_type job_data,
   input  var logic seed_load,
   input  var logic [SEED_W-1:0] seed_value,
   output var logic rsp_valid,
   input  var logic rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_FOLD  = 6'b000100,
      ST_SCALE = 6'b001000,
      ST_ADD   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [SEED_W-1:0] seed_ff, seed_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [SCALE_W-1:0] sum_ff, sum_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic [SEED_W:0] fold;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign job_pop = (state_ff == ST_IDLE) && job_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Fold the high part of the product back in, since 2^31 is one mod 2^31-1
   assign fold = {1'b0, prod_ff[SEED_W-1:0]}
               + (SEED_W + 1)'(prod_ff[PROD_W-1:SEED_W]);

   // Sequence one job through multiply, fold, scale, add and output
   always_comb begin
      state_in = state_ff;
      seed_in = seed_ff;
      prod_in = prod_ff;
      scale_in = scale_ff;
      sum_in = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_ready) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = PROD_W'(seed_ff) * PROD_W'(LcgMult);
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            if (fold >= {1'b0, LcgMod}) begin
               seed_in = SEED_W'(fold - {1'b0, LcgMod});
            end else begin
               seed_in = fold[SEED_W-1:0];
            end
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            scale_in = SCALE_W'(seed_ff) * SCALE_W'(job_data.diff);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in = scale_ff + SCALE_W'(seed_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_data_in.ranged_value = job_data.low + sum_ff[SCALE_W-1:SEED_W];
               rsp_data_in.unit_fraction = seed_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Load the seed on a configuration transfer
      if (seed_load) begin
         seed_in = seed_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seed_ff <= SeedReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seed_ff <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      scale_ff <= scale_in;
      sum_ff <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

### rtl/lehmer_ranged_random.sv
// From request transfer to result valid a job passes the queue, then pop,
//   multiply, fold, scale, add and output load, which waits while a held result
//   is stalled; the six-state back end takes one job at a time on one seed.
// Requests queue up while the back end works, so the front stalls only when full.
// Reset (synchronous): seed returns to 12345678, queue empties, no result valid.
`default_nettype none

module lehmer_ranged_random
   import lrr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  var logic clock,
   input  var logic reset,
   input  var logic req_valid,
   output var logic req_stall,
   input  var req_type req_data,
   output var logic rsp_valid,
   input  var logic rsp_stall,
   output rsp_type rsp_data,
   input  var logic csr_valid,
   output var logic csr_ready,
   input  var logic [SEED_W-1:0] csr_data
);

   job_type job_push_data;
   job_type job_pop_data;
   logic queue_full;
   logic queue_not_empty;
   logic job_pop;
   logic req_transfer;

   assign req_stall = queue_full;
   assign req_transfer = req_valid && !queue_full;
   assign csr_ready = 1'b1;

   lrr_front u_front (
      .req_data (req_data),
      .job_data (job_push_data)
   );

   lrr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_transfer),
      .push_data (job_push_data),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (job_pop),
      .pop_data  (job_pop_data)
   );

   lrr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_ready  (queue_not_empty),
      .job_pop    (job_pop),
      .job_data   (job_pop_data),
      .seed_load  (csr_valid && csr_ready),
      .seed_value (csr_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
